// ===== rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned OFS_W  = 21;
    localparam int unsigned SIZE_W = 21;
    localparam int unsigned REQ_W  = 21;
    localparam int unsigned WANT_W = 22;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'hC040_0000;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;

    typedef struct packed {
        logic              opcode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] payload_address;
    } t_out_beat;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_NULL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [WANT_W-1:0] want;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [OFS_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_FNEXT,
        S_SHIFT,
        S_WR1,
        S_WR2,
        S_RESULT
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_unit.sv =====
`default_nettype none
// first-fit heap allocator: each input beat is an allocate or a free; each gives exactly one
// result beat, in order. the block table lives in a single-port-write, single-port-read memory
// of MAX_BLOCKS entries kept in address order. a command queue of two entries sits between the
// front (classifies beats) and the back (walks the table). an item popped in the idle state
// is compared against the entries one per cycle up to the first fit or the matching address;
// a hit writes the table before the result register is loaded, a miss scans the whole table
// and goes straight to it. an allocate that splits adds a second write and first moves the
// entries above the hit up; a free that merges first moves the entries above it down. a null
// free goes straight to the result register. after reset, the initial free block is written
// before the first beat is taken. heap_base may be written only while idle.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 1048576,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_BLOCKS   = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request beats
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_beat          i_in_data,
    // result beats
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_beat              o_out_data,
    // heap base register
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ADDR_W-1:0] i_cfg_wr_data
);

    logic [ADDR_W-1:0] r_heap_base;

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;
    logic    booting;

    // virtual base added to every payload offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= HEAP_BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_heap_base <= i_cfg_wr_data;
        end
    end

    // front: round sizes, spot null frees
    ffha_front u_front (
        .i_in_data  (i_in_data),
        .i_in_valid (i_in_valid),
        .i_q_stat   (q_stat),
        .i_hold     (booting),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // two-deep command queue decouples intake from table work
    ffha_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // back: table scan, split, merge, result register
    ffha_back #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_stat    (q_stat),
        .i_heap_base (r_heap_base),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_init      (booting),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/ffha_front.sv =====
`default_nettype none
module ffha_front
    import ffha_pkg::*;
(
    input  wire t_in_beat i_in_data,
    input  wire logic     i_in_valid,
    input  wire t_q_stat  i_q_stat,
    input  wire logic     i_hold,
    output logic          o_in_stall,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic [WANT_W-1:0] req_x;

    // round the request up to a multiple of 8
    assign req_x = {1'b0, i_in_data.request_bytes} + WANT_W'(7);

    always_comb begin
        o_cmd.want = req_x & ~WANT_W'(7);
        o_cmd.addr = i_in_data.release_address;
        if (i_in_data.opcode == OP_ALLOC) begin
            o_cmd.kind = CMD_ALLOC;
        end else if (i_in_data.release_address == '0) begin
            o_cmd.kind = CMD_NULL;
        end else begin
            o_cmd.kind = CMD_FREE;
        end
    end

    assign o_in_stall = i_q_stat.full | i_hold;
    assign o_push     = i_in_valid & ~o_in_stall;

endmodule
`default_nettype wire

// ===== rtl/ffha_cmdq.sv =====
`default_nettype none
module ffha_cmdq
    import ffha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

endmodule
`default_nettype wire

// ===== rtl/ffha_back.sv =====
`default_nettype none
module ffha_back
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 1048576,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_BLOCKS   = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_head,
    input  wire t_q_stat           i_q_stat,
    input  wire logic [ADDR_W-1:0] i_heap_base,
    input  wire logic              i_out_stall,
    output logic                   o_pop,
    output logic                   o_init,
    output logic                   o_out_valid,
    output t_out_beat              o_out_data
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [SIZE_W-1:0] HDR_C     = SIZE_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_A     = ADDR_W'(HEADER_BYTES);
    localparam logic [WANT_W:0]   SPLIT_MIN = (WANT_W + 1)'(HEADER_BYTES + 8);
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0]     MAX_C     = CW'(MAX_BLOCKS);

    typedef struct packed {
        logic          en;
        logic [IW-1:0] addr;
        t_entry        data;
    } t_wr;

    t_entry      mem [MAX_BLOCKS];

    t_back_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_new_count, n_new_count;
    t_cmd        r_cmd, n_cmd;
    logic [CW-1:0] r_ridx, n_ridx;
    logic        r_qv, n_qv;
    logic [IW-1:0] r_qidx, n_qidx;
    t_entry      r_q;
    t_entry      r_prev, n_prev;
    logic [IW-1:0] r_hit, n_hit;
    t_entry      r_hent, n_hent;
    t_entry      r_pent, n_pent;
    logic [IW-1:0] r_src, n_src;
    logic [IW-1:0] r_src_last, n_src_last;
    logic [IW-1:0] r_dst, n_dst;
    logic        r_pend, n_pend;
    logic        r_rd_more, n_rd_more;
    logic        r_up, n_up;
    logic [1:0]  r_dist, n_dist;
    t_wr         r_w1, n_w1;
    t_wr         r_w2, n_w2;
    t_out_beat   r_res, n_res;
    logic        r_ov, n_ov;
    t_out_beat   r_out, n_out;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;

    logic [CW:0]         hit_x;
    logic [CW:0]         cnt_x;
    logic [CW:0]         drop_base;
    logic [CW:0]         src0;
    logic [1:0]          drop_d;
    logic                next_free;
    logic                prev_free;
    logic [SIZE_W-1:0]   merged;
    logic                split;
    logic                q_hit;
    logic [ADDR_W-1:0]   q_addr;
    logic [ADDR_W-1:0]   h_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_ov    <= 1'b0;
            r_qv    <= 1'b0;
            r_pend  <= 1'b0;
            r_rd_more <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_qv    <= n_qv;
            r_pend  <= n_pend;
            r_rd_more <= n_rd_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_count <= n_new_count;
        r_cmd       <= n_cmd;
        r_ridx      <= n_ridx;
        r_qidx      <= n_qidx;
        r_prev      <= n_prev;
        r_hit       <= n_hit;
        r_hent      <= n_hent;
        r_pent      <= n_pent;
        r_src       <= n_src;
        r_src_last  <= n_src_last;
        r_dst       <= n_dst;
        r_up        <= n_up;
        r_dist      <= n_dist;
        r_w1        <= n_w1;
        r_w2        <= n_w2;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign hit_x = {{(CW + 1 - IW){1'b0}}, r_hit};
    assign cnt_x = {1'b0, r_count};

    // payload address of the entry under the scan and of the hit entry
    assign q_addr = i_heap_base + {{(ADDR_W - OFS_W){1'b0}}, r_q.offset} + HDR_A;
    assign h_addr = i_heap_base + {{(ADDR_W - OFS_W){1'b0}}, r_hent.offset} + HDR_A;

    always_comb begin
        if (r_cmd.kind == CMD_ALLOC) begin
            q_hit = r_q.is_free && ({1'b0, r_q.size} >= r_cmd.want);
        end else begin
            q_hit = !r_q.is_free && (q_addr == r_cmd.addr);
        end
    end

    // neighbors of the freed entry
    assign next_free = (hit_x + 1'b1 < cnt_x) && r_q.is_free;
    assign prev_free = (r_hit != '0) && r_pent.is_free;
    assign merged    = next_free ? (r_hent.size + HDR_C + r_q.size) : r_hent.size;
    assign drop_d    = (next_free && prev_free) ? 2'd2 : 2'd1;
    assign drop_base = prev_free ? hit_x : hit_x + 1'b1;
    assign src0      = drop_base + {{(CW - 1){1'b0}}, drop_d};

    assign split = ({2'b0, r_hent.size} >= {1'b0, r_cmd.want} + SPLIT_MIN)
                   && (r_count < MAX_C);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_new_count = r_new_count;
        n_cmd       = r_cmd;
        n_ridx      = r_ridx;
        n_qv        = 1'b0;
        n_qidx      = r_qidx;
        n_prev      = r_prev;
        n_hit       = r_hit;
        n_hent      = r_hent;
        n_pent      = r_pent;
        n_src       = r_src;
        n_src_last  = r_src_last;
        n_dst       = r_dst;
        n_pend      = 1'b0;
        n_rd_more   = r_rd_more;
        n_up        = r_up;
        n_dist      = r_dist;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_res       = r_res;
        n_ov        = r_ov & i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = '0;
        o_pop       = 1'b0;

        case (r_state)
            S_INIT: begin
                // one free block spanning the heap
                mem_we  = 1'b1;
                mem_wd  = '{offset: '0, size: INIT_SIZE, is_free: 1'b1};
                n_state = S_IDLE;
            end

            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_head;
                    n_ridx = '0;
                    n_res  = '{status: ST_DONE, payload_address: '0};
                    n_state = (i_head.kind == CMD_NULL) ? S_RESULT : S_SCAN;
                end
            end

            S_SCAN: begin
                // read one entry ahead of the compare
                mem_re = r_ridx < r_count;
                mem_ra = r_ridx[IW-1:0];
                if (mem_re) begin
                    n_ridx = r_ridx + 1'b1;
                    n_qv   = 1'b1;
                    n_qidx = r_ridx[IW-1:0];
                end
                if (r_qv) begin
                    n_prev = r_q;
                    if (q_hit) begin
                        n_hit  = r_qidx;
                        n_hent = r_q;
                        n_pent = r_prev;
                        n_state = (r_cmd.kind == CMD_ALLOC) ? S_ALLOC : S_FNEXT;
                    end else if ({1'b0, r_qidx} == cnt_x[IW:0] - 1'b1) begin
                        n_res.status = (r_cmd.kind == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
                        n_state = S_RESULT;
                    end
                end
            end

            S_ALLOC: begin
                n_res.payload_address = h_addr;
                n_w2.en = 1'b0;
                if (split) begin
                    n_w1.en   = 1'b1;
                    n_w1.addr = r_hit + 1'b1;
                    n_w1.data = '{
                        offset:  r_hent.offset + HDR_C + r_cmd.want[SIZE_W-1:0],
                        size:    r_hent.size - r_cmd.want[SIZE_W-1:0] - HDR_C,
                        is_free: 1'b1};
                    n_w2.en   = 1'b1;
                    n_w2.addr = r_hit;
                    n_w2.data = '{offset: r_hent.offset, size: r_cmd.want[SIZE_W-1:0],
                                  is_free: 1'b0};
                    n_new_count = r_count + 1'b1;
                    // open a slot above the hit, top entry first
                    if (hit_x + 1'b1 <= cnt_x - 1'b1) begin
                        n_up       = 1'b1;
                        n_src      = IW'(r_count - 1'b1);
                        n_src_last = r_hit + 1'b1;
                        n_rd_more  = 1'b1;
                        n_state    = S_SHIFT;
                    end else begin
                        n_state = S_WR1;
                    end
                end else begin
                    n_w1.en     = 1'b1;
                    n_w1.addr   = r_hit;
                    n_w1.data   = '{offset: r_hent.offset, size: r_hent.size, is_free: 1'b0};
                    n_new_count = r_count;
                    n_state     = S_WR1;
                end
            end

            S_FNEXT: begin
                // r_q holds the successor here
                n_w1.en = 1'b1;
                n_w2.en = 1'b0;
                if (prev_free) begin
                    n_w1.addr = r_hit - 1'b1;
                    n_w1.data = '{offset: r_pent.offset,
                                  size: r_pent.size + HDR_C + merged, is_free: 1'b1};
                end else begin
                    n_w1.addr = r_hit;
                    n_w1.data = '{offset: r_hent.offset, size: merged, is_free: 1'b1};
                end
                n_new_count = r_count;
                n_state     = S_WR1;
                if (next_free || prev_free) begin
                    n_new_count = CW'(cnt_x - {{(CW - 1){1'b0}}, drop_d});
                    if (src0 <= cnt_x - 1'b1) begin
                        n_up       = 1'b0;
                        n_dist     = drop_d;
                        n_src      = src0[IW-1:0];
                        n_src_last = IW'(r_count - 1'b1);
                        n_rd_more  = 1'b1;
                        n_state    = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // read one entry and write the one read the cycle before
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_dst;
                    mem_wd = r_q;
                end
                if (r_rd_more) begin
                    mem_re = 1'b1;
                    mem_ra = r_src;
                    n_pend = 1'b1;
                    n_dst  = r_up ? r_src + 1'b1 : r_src - IW'(r_dist);
                    if (r_src == r_src_last) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_src = r_up ? r_src - 1'b1 : r_src + 1'b1;
                    end
                end else begin
                    n_state = S_WR1;
                end
            end

            S_WR1: begin
                mem_we  = r_w1.en;
                mem_wa  = r_w1.addr;
                mem_wd  = r_w1.data;
                n_count = r_new_count;
                n_state = r_w2.en ? S_WR2 : S_RESULT;
            end

            S_WR2: begin
                mem_we  = 1'b1;
                mem_wa  = r_w2.addr;
                mem_wd  = r_w2.data;
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_init      = r_state == S_INIT;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAX_C))
        else $error("block count out of range");

    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_RESULT))
        else $error("result beat raised outside the result state");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("table read and write collide");

    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(r_state == S_WR1))
        else $error("block count changed outside commit");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
    import ffha_pkg::*;

    localparam int unsigned HEAP_SZ  = 1048576;
    localparam int unsigned HDR_SZ   = 16;
    localparam int unsigned TBL_SZ   = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_data;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    first_fit_heap_allocator_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // shadow copy of the block table
    logic [31:0] shadow_base;
    logic [31:0] shadow_ofs  [TBL_SZ];
    logic [31:0] shadow_size [TBL_SZ];
    logic        shadow_free [TBL_SZ];
    int unsigned shadow_count;

    t_out_beat   expected_results[$];
    logic [31:0] live_addrs[$];
    int          mismatch_count;
    int          result_count;
    int          beat_count;
    bit          hold_off;
    int          grants, no_fits, bad_frees;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic void table_reset();
        for (int k = 0; k < TBL_SZ; k++) begin
            shadow_ofs[k] = 0;
            shadow_size[k] = 0;
            shadow_free[k] = 1'b0;
        end
        shadow_size[0] = HEAP_SZ - HDR_SZ;
        shadow_free[0] = 1'b1;
        shadow_count = 1;
    endfunction

    function automatic logic [31:0] payload_at(int unsigned i);
        return shadow_base + shadow_ofs[i] + HDR_SZ;
    endfunction

    function automatic void remove_entry(int unsigned i);
        for (int unsigned k = i; k + 1 < shadow_count; k++) begin
            shadow_ofs[k] = shadow_ofs[k+1];
            shadow_size[k] = shadow_size[k+1];
            shadow_free[k] = shadow_free[k+1];
        end
        shadow_count--;
        shadow_ofs[shadow_count] = 0;
        shadow_size[shadow_count] = 0;
        shadow_free[shadow_count] = 1'b0;
    endfunction

    // first-fit predictor with split and two-sided coalescing
    function automatic t_out_beat predict_heap(t_in_beat b);
        t_out_beat   r;
        logic [31:0] want;
        logic [31:0] have;
        int unsigned i;
        r.status = ST_DONE;
        r.payload_address = '0;
        if (b.opcode == OP_ALLOC) begin
            want = (32'(b.request_bytes) + 7) & ~32'd7;
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_free[i] && shadow_size[i] >= want) break;
            end
            if (i == shadow_count) begin
                r.status = ST_NO_FIT;
                return r;
            end
            have = shadow_size[i];
            if (have >= want + HDR_SZ + 8 && shadow_count < TBL_SZ) begin
                for (int unsigned k = shadow_count; k > i + 1; k--) begin
                    shadow_ofs[k] = shadow_ofs[k-1];
                    shadow_size[k] = shadow_size[k-1];
                    shadow_free[k] = shadow_free[k-1];
                end
                shadow_ofs[i+1] = shadow_ofs[i] + HDR_SZ + want;
                shadow_size[i+1] = have - want - HDR_SZ;
                shadow_free[i+1] = 1'b1;
                shadow_size[i] = want;
                shadow_count++;
            end
            shadow_free[i] = 1'b0;
            r.payload_address = payload_at(i);
            return r;
        end
        if (b.release_address == 0) return r;
        for (i = 0; i < shadow_count; i++) begin
            if (!shadow_free[i] && payload_at(i) == b.release_address) break;
        end
        if (i == shadow_count) begin
            r.status = ST_BAD_FREE;
            return r;
        end
        shadow_free[i] = 1'b1;
        if (i + 1 < shadow_count && shadow_free[i+1]) begin
            shadow_size[i] += HDR_SZ + shadow_size[i+1];
            remove_entry(i + 1);
        end
        if (i > 0 && shadow_free[i-1]) begin
            shadow_size[i-1] += HDR_SZ + shadow_size[i];
            remove_entry(i);
        end
        return r;
    endfunction

    // sends one beat after a random gap, predicts at acceptance
    // valid stays up after acceptance until the next beat or a drain drops it
    task automatic send_beat(input t_in_beat b);
        t_out_beat r;
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_heap(b);
        expected_results.push_back(r);
        if (b.opcode == OP_ALLOC && r.status == ST_DONE) live_addrs.push_back(r.payload_address);
        beat_count++;
    endtask

    function automatic t_in_beat make_alloc(input int unsigned bytes);
        t_in_beat b;
        b.opcode = OP_ALLOC;
        b.request_bytes = bytes[20:0];
        b.release_address = $urandom();
        return b;
    endfunction

    function automatic t_in_beat make_free(input logic [31:0] addr);
        t_in_beat b;
        b.opcode = ~OP_ALLOC;
        b.request_bytes = REQ_W'($urandom());
        b.release_address = addr;
        return b;
    endfunction

    // free a random live block and drop it from the list
    task automatic free_some();
        int idx;
        logic [31:0] a;
        idx = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        send_beat(make_free(a));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TBL_SZ * 3) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        wait_drain();
        // every live block now reads at a shifted address, so start clean
        while (live_addrs.size() != 0) free_some();
        wait_drain();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        shadow_base = v;
    endtask

    task automatic test_directed();
        logic [31:0] a;
        send_beat(make_free(32'd0));                // null free
        send_beat(make_alloc(0));                   // zero-byte allocate splits
        send_beat(make_alloc(1));
        send_beat(make_alloc(7));
        send_beat(make_alloc(8));
        send_beat(make_alloc(21'h1FFFFF));          // no fit
        send_beat(make_alloc(HEAP_SZ));             // no fit after splits
        send_beat(make_free(32'hFFFF_FFFF));        // unknown address
        a = live_addrs[1];
        send_beat(make_free(a + 1));                // near miss
        send_beat(make_free(a));
        send_beat(make_free(a));                    // double free
        live_addrs.delete(1);
        while (live_addrs.size() != 0) free_some(); // coalesce back to one block
        send_beat(make_alloc(HEAP_SZ - HDR_SZ));    // whole heap, no split
        send_beat(make_alloc(0));                   // nothing left
        free_some();
    endtask

    // fills the table to its limit so a fitting block is granted whole
    task automatic test_table_full();
        for (int n = 0; n < TBL_SZ + 4; n++) send_beat(make_alloc($urandom_range(0, 64)));
        for (int n = 0; n < 20; n++) free_some();
        for (int n = 0; n < 10; n++) send_beat(make_alloc($urandom_range(0, 200)));
        while (live_addrs.size() != 0) free_some();
    endtask

    task automatic test_random(input int n_items);
        int pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && live_addrs.size() < 60) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(make_alloc($urandom_range(0, 21'h1FFFFF)));
                else
                    send_beat(make_alloc($urandom_range(0, 4096)));
            end else if (pick < 88 && live_addrs.size() != 0) begin
                free_some();
            end else if (pick < 94) begin
                send_beat(make_free($urandom()));
            end else if (pick < 97) begin
                send_beat(make_free(32'd0));
            end else begin
                send_beat(make_free(live_addrs.size() != 0 ? live_addrs[0] + 8 : 32'd4));
            end
        end
    endtask

    // receiver holds off long enough for the command queue to fill
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++) send_beat(make_alloc($urandom_range(0, 128)));
        join
    endtask

    // result stall: random per beat, sometimes none, forced during hold-off
    initial begin
        int wait_cycles;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_cycles != 0 || hold_off) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected beat", o_out_data.payload_address, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status)
                    report("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.payload_address !== want.payload_address)
                    report("payload_address", o_out_data.payload_address,
                           want.payload_address);
                case (want.status)
                    ST_DONE:   grants++;
                    ST_NO_FIT: no_fits++;
                    default:   bad_frees++;
                endcase
            end
            result_count++;
        end
    end

    initial begin
        #50_000_000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        result_count = 0;
        beat_count = 0;
        grants = 0;
        no_fits = 0;
        bad_frees = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        shadow_base = HEAP_BASE_RESET;
        table_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(500);
        write_base(32'h0000_0000);
        test_random(400);
        write_base(32'hFFFF_FFF0);                  // payload addresses wrap
        test_directed();
        test_random(400);
        write_base(32'h1234_5678);
        test_random(400);
        wait_drain();

        $display("%0d beats sent, %0d results: %0d done, %0d no fit, %0d bad free",
                 beat_count, result_count, grants, no_fits, bad_frees);
        $display("covered splits, full table, coalescing, base wrap and a long output stall");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== first_fit_heap_allocator_unit.f =====
rtl/ffha_pkg.sv
rtl/ffha_front.sv
rtl/ffha_cmdq.sv
rtl/ffha_back.sv
rtl/first_fit_heap_allocator_unit.sv
bench/testbench.sv
